>>> rtl/core/tpst_pkg.sv
`timescale 1ns / 1ps

package tpst_pkg;

    localparam int SLOTS       = 8;
    localparam int MAX_BYTES   = 64;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BYTE_IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int STORE_DEPTH = SLOTS * (2 ** BYTE_IDX_W);
    localparam int STORE_AW    = SLOT_W + BYTE_IDX_W;
    localparam int LEN_W       = 7;
    localparam int TIME_W      = 32;
    localparam int BYTE_W      = 8;

    typedef enum logic [1:0] {
        OP_ADD_START = 2'd0,
        OP_ADD_BYTE  = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_FIND      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ADD_OK  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_NOT_DUE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } state_t;

endpackage

>>> rtl/core/tpst_ram.sv
`timescale 1ns / 1ps

module tpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/timed_packet_slot_table.sv
`timescale 1ns / 1ps
// Add start, add byte and clear act when accepted; add start and a find that returns
// nothing or an empty packet show their result in the cycle after the request.
// A find that returns n bytes reads the packet store once per byte; each byte passes
// the RAM read register, then the result registers; one byte per cycle unless stalled.
// Reset clears every slot time and length, the pending add and prepare_time at once;
// the packet store is not cleared because only fully written slots are ever read.
module timed_packet_slot_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] time_value,
    input  logic [6:0]  packet_length,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [31:0] found_time,
    output logic [6:0]  result_length,
    output logic [7:0]  result_byte,
    output logic        byte_valid,
    output logic        last
);

    logic [tpst_pkg::TIME_W-1:0] prepare_time_reg;
    logic [tpst_pkg::TIME_W-1:0] slot_time_reg [tpst_pkg::SLOTS];
    logic [tpst_pkg::LEN_W-1:0]  slot_len_reg  [tpst_pkg::SLOTS];

    logic                        pend_active_reg;
    logic [tpst_pkg::SLOT_W-1:0] pend_slot_reg;
    logic [tpst_pkg::TIME_W-1:0] pend_time_reg;
    logic [tpst_pkg::LEN_W-1:0]  pend_count_reg;
    logic [tpst_pkg::LEN_W-1:0]  pend_total_reg;

    tpst_pkg::state_t            state_reg, state_next;
    logic [tpst_pkg::SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [tpst_pkg::LEN_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [tpst_pkg::LEN_W-1:0]  rd_len_reg, rd_len_next;
    logic [tpst_pkg::TIME_W-1:0] rd_time_reg, rd_time_next;

    logic                        res_valid_reg, res_valid_next;
    tpst_pkg::status_t           status_reg, status_next;
    logic [tpst_pkg::TIME_W-1:0] found_time_reg, found_time_next;
    logic [tpst_pkg::LEN_W-1:0]  result_length_reg, result_length_next;
    logic [tpst_pkg::BYTE_W-1:0] result_byte_reg, result_byte_next;
    logic                        byte_valid_reg, byte_valid_next;
    logic                        last_reg, last_next;
    logic                        load;

    logic                          accept;
    logic                          out_free;
    tpst_pkg::op_t                 op;
    logic [tpst_pkg::LEN_W-1:0]    add_len;
    logic [tpst_pkg::TIME_W-1:0]   due;
    logic                          free_hit;
    logic [tpst_pkg::SLOT_W-1:0]   free_idx;
    logic                          due_hit;
    logic [tpst_pkg::SLOT_W-1:0]   due_idx;
    logic [tpst_pkg::LEN_W-1:0]    rd_cnt_inc;
    logic [tpst_pkg::LEN_W-1:0]    pend_count_inc;
    logic                          byte_take;

    logic                          ram_we;
    logic [tpst_pkg::STORE_AW-1:0] ram_waddr;
    logic                          ram_re;
    logic [tpst_pkg::STORE_AW-1:0] ram_raddr;
    logic [tpst_pkg::BYTE_W-1:0]   ram_rdata;

    tpst_ram #(
        .WIDTH (tpst_pkg::BYTE_W),
        .DEPTH (tpst_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? prepare_time_reg : 32'd0;

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = !((state_reg == tpst_pkg::S_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;
    assign op        = tpst_pkg::op_t'(operation);
    assign due       = time_value + prepare_time_reg;
    assign add_len   = (packet_length > tpst_pkg::LEN_W'(tpst_pkg::MAX_BYTES))
                     ? tpst_pkg::LEN_W'(tpst_pkg::MAX_BYTES) : packet_length;

    assign rd_cnt_inc     = rd_cnt_reg + tpst_pkg::LEN_W'(1);
    assign pend_count_inc = pend_count_reg + tpst_pkg::LEN_W'(1);
    assign byte_take      = accept && (op == tpst_pkg::OP_ADD_BYTE) && pend_active_reg
                          && (pend_count_reg < tpst_pkg::LEN_W'(tpst_pkg::MAX_BYTES));

    assign ram_we    = byte_take;
    assign ram_waddr = {pend_slot_reg, pend_count_reg[tpst_pkg::BYTE_IDX_W-1:0]};

    always_comb
    begin
        free_hit = 1'b0;
        free_idx = '0;
        due_hit  = 1'b0;
        due_idx  = '0;
        for (int i = tpst_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (slot_time_reg[i] == '0)
            begin
                free_hit = 1'b1;
                free_idx = tpst_pkg::SLOT_W'(i);
            end
            if ((slot_time_reg[i] != '0) && (slot_time_reg[i] <= due))
            begin
                due_hit = 1'b1;
                due_idx = tpst_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        rd_slot_next       = rd_slot_reg;
        rd_cnt_next        = rd_cnt_reg;
        rd_len_next        = rd_len_reg;
        rd_time_next       = rd_time_reg;
        ram_re             = 1'b0;
        ram_raddr          = {rd_slot_reg, rd_cnt_inc[tpst_pkg::BYTE_IDX_W-1:0]};
        load               = 1'b0;
        status_next        = tpst_pkg::ST_ADD_OK;
        found_time_next    = '0;
        result_length_next = '0;
        result_byte_next   = '0;
        byte_valid_next    = 1'b0;
        last_next          = 1'b1;
        unique case (state_reg)
            tpst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        tpst_pkg::OP_ADD_START:
                        begin
                            load        = 1'b1;
                            status_next = free_hit ? tpst_pkg::ST_ADD_OK : tpst_pkg::ST_FULL;
                        end
                        tpst_pkg::OP_FIND:
                        begin
                            if (!due_hit)
                            begin
                                load        = 1'b1;
                                status_next = tpst_pkg::ST_NOT_DUE;
                            end
                            else if (slot_len_reg[due_idx] == '0)
                            begin
                                load            = 1'b1;
                                status_next     = tpst_pkg::ST_FOUND;
                                found_time_next = slot_time_reg[due_idx];
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = {due_idx, {tpst_pkg::BYTE_IDX_W{1'b0}}};
                                rd_slot_next = due_idx;
                                rd_cnt_next  = '0;
                                rd_len_next  = slot_len_reg[due_idx];
                                rd_time_next = slot_time_reg[due_idx];
                                state_next   = tpst_pkg::S_LOAD;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            tpst_pkg::S_LOAD:
            begin
                if (out_free)
                begin
                    load               = 1'b1;
                    status_next        = tpst_pkg::ST_FOUND;
                    found_time_next    = rd_time_reg;
                    result_length_next = rd_len_reg;
                    result_byte_next   = ram_rdata;
                    byte_valid_next    = 1'b1;
                    last_next          = (rd_cnt_inc == rd_len_reg);
                    rd_cnt_next        = rd_cnt_inc;
                    if (rd_cnt_inc == rd_len_reg)
                    begin
                        state_next = tpst_pkg::S_IDLE;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = tpst_pkg::S_IDLE;
            end
        endcase
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tpst_pkg::S_IDLE;
            res_valid_reg    <= 1'b0;
            prepare_time_reg <= '0;
            pend_active_reg  <= 1'b0;
            pend_slot_reg    <= '0;
            pend_time_reg    <= '0;
            pend_count_reg   <= '0;
            pend_total_reg   <= '0;
            rd_cnt_reg       <= '0;
            rd_len_reg       <= '0;
            for (int i = 0; i < tpst_pkg::SLOTS; i++)
            begin
                slot_time_reg[i] <= '0;
                slot_len_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_len_reg    <= rd_len_next;

            if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            begin
                prepare_time_reg <= pwdata;
            end

            if (accept && (op != tpst_pkg::OP_ADD_BYTE)
                && !((op == tpst_pkg::OP_ADD_START) && free_hit && (add_len != '0)))
            begin
                pend_active_reg <= 1'b0;
            end

            if (byte_take)
            begin
                pend_count_reg <= pend_count_inc;
                if (pend_count_inc >= pend_total_reg)
                begin
                    slot_time_reg[pend_slot_reg] <= pend_time_reg;
                    slot_len_reg[pend_slot_reg]  <= pend_total_reg;
                    pend_active_reg              <= 1'b0;
                end
            end

            if (accept && (op == tpst_pkg::OP_ADD_START) && free_hit)
            begin
                if (add_len == '0)
                begin
                    slot_time_reg[free_idx] <= time_value;
                    slot_len_reg[free_idx]  <= '0;
                end
                else
                begin
                    pend_active_reg <= 1'b1;
                    pend_slot_reg   <= free_idx;
                    pend_time_reg   <= time_value;
                    pend_count_reg  <= '0;
                    pend_total_reg  <= add_len;
                end
            end

            if (accept && (op == tpst_pkg::OP_CLEAR))
            begin
                for (int i = 0; i < tpst_pkg::SLOTS; i++)
                begin
                    if (slot_time_reg[i] <= time_value)
                    begin
                        slot_time_reg[i] <= '0;
                    end
                end
            end

            if (accept && (op == tpst_pkg::OP_FIND) && due_hit)
            begin
                slot_time_reg[due_idx] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        rd_time_reg <= rd_time_next;
        if (load)
        begin
            status_reg        <= status_next;
            found_time_reg    <= found_time_next;
            result_length_reg <= result_length_next;
            result_byte_reg   <= result_byte_next;
            byte_valid_reg    <= byte_valid_next;
            last_reg          <= last_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign found_time    = found_time_reg;
    assign result_length = result_length_reg;
    assign result_byte   = result_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign last          = last_reg;

    a_load_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpst_pkg::S_LOAD) |-> (rd_cnt_reg < rd_len_reg))
        else $error("packet read index passed the packet length");

    a_pending_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_active_reg |-> (pend_count_reg < pend_total_reg))
        else $error("pending add byte count reached its total while still pending");

    a_idle_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (state_reg == tpst_pkg::S_IDLE)) |-> last_reg)
        else $error("result waiting in idle is not the last of its request");

    a_byte_only_on_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && byte_valid_reg) |-> (status_reg == tpst_pkg::ST_FOUND))
        else $error("packet byte shown with a status other than found");

    a_load_leaves_idle_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == tpst_pkg::S_LOAD) && out_free && (rd_cnt_inc == rd_len_reg))
        |=> ((state_reg == tpst_pkg::S_IDLE) && res_valid_reg && last_reg))
        else $error("final packet byte did not end the read");

endmodule

>>> test/tpst_checker.sv
`timescale 1ns / 1ps

package tpst_tb_pkg;

    localparam logic [2:0] REG_PREPARE_TIME = 3'd0;

endpackage

module tpst_checker
    import tpst_pkg::*;
    import tpst_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] time_value,
    input  logic [6:0]  packet_length,
    input  logic [7:0]  data_byte,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [1:0]  status,
    input  logic [31:0] found_time,
    input  logic [6:0]  result_length,
    input  logic [7:0]  result_byte,
    input  logic        byte_valid,
    input  logic        last,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          packets_found,
    output int          full_answers
);

    typedef struct {
        status_t           status;
        logic [TIME_W-1:0] ftime;
        logic [LEN_W-1:0]  size;
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              final_one;
    } tx_result_t;

    logic [TIME_W-1:0] slot_due [SLOTS];
    logic [LEN_W-1:0]  slot_size [SLOTS];
    logic [BYTE_W-1:0] slot_bytes [SLOTS][MAX_BYTES];
    logic              load_busy;
    int                load_slot;
    logic [TIME_W-1:0] load_time;
    int                load_count;
    int                load_total;
    logic [31:0]       lead_time;
    tx_result_t        awaited_results [$];
    tx_result_t        want;

    function automatic void await_result(status_t st, logic [TIME_W-1:0] ft,
                                         logic [LEN_W-1:0] n, logic [BYTE_W-1:0] d,
                                         logic v, logic f);
        tx_result_t r;
        r.status    = st;
        r.ftime     = ft;
        r.size      = n;
        r.data      = d;
        r.has_byte  = v;
        r.final_one = f;
        awaited_results.push_back(r);
    endfunction

    function automatic void update_table(op_t op, logic [TIME_W-1:0] t,
                                         logic [LEN_W-1:0] len, logic [BYTE_W-1:0] d);
        int                slot;
        int                n;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] ft;
        if (op == OP_ADD_BYTE)
        begin
            if (load_busy && load_count < MAX_BYTES)
            begin
                slot_bytes[load_slot][load_count] = d;
                load_count++;
                if (load_count >= load_total)
                begin
                    slot_due[load_slot]  = load_time;
                    slot_size[load_slot] = LEN_W'(load_total);
                    load_busy            = 1'b0;
                end
            end
            return;
        end
        load_busy = 1'b0;
        slot      = -1;
        case (op)
            OP_ADD_START:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_due[i] == '0)
                        slot = i;
                if (slot < 0)
                    await_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                else
                begin
                    n = (int'(len) > MAX_BYTES) ? MAX_BYTES : int'(len);
                    if (n == 0)
                    begin
                        slot_due[slot]  = t;
                        slot_size[slot] = '0;
                    end
                    else
                    begin
                        load_busy  = 1'b1;
                        load_slot  = slot;
                        load_time  = t;
                        load_count = 0;
                        load_total = n;
                    end
                    await_result(ST_ADD_OK, '0, '0, '0, 1'b0, 1'b1);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_due[i] <= t)
                        slot_due[i] = '0;
            end
            default:
            begin
                due = t + lead_time;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_due[i] != '0 && slot_due[i] <= due)
                        slot = i;
                if (slot < 0)
                    await_result(ST_NOT_DUE, '0, '0, '0, 1'b0, 1'b1);
                else
                begin
                    ft             = slot_due[slot];
                    slot_due[slot] = '0;
                    n              = int'(slot_size[slot]);
                    if (n == 0)
                        await_result(ST_FOUND, ft, '0, '0, 1'b0, 1'b1);
                    for (int k = 0; k < n; k++)
                        await_result(ST_FOUND, ft, LEN_W'(n), slot_bytes[slot][k], 1'b1,
                                     k == n - 1);
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] expected_value,
                                          logic [31:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected_value, actual_value);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_due[i]  = '0;
                slot_size[i] = '0;
            end
            load_busy       = 1'b0;
            load_slot       = 0;
            load_time       = '0;
            load_count      = 0;
            load_total      = 0;
            lead_time       = '0;
            fail_count      = 0;
            results_checked = 0;
            packets_found   = 0;
            full_answers    = 0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d, found_time 0x%0h", status,
                           found_time);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("found_time", want.ftime, found_time);
                    compare_field("result_length", 32'(want.size), 32'(result_length));
                    compare_field("result_byte", 32'(want.data), 32'(result_byte));
                    compare_field("byte_valid", 32'(want.has_byte), 32'(byte_valid));
                    compare_field("last", 32'(want.final_one), 32'(last));
                    results_checked++;
                    if (want.status == ST_FOUND && want.final_one)
                        packets_found++;
                    if (want.status == ST_FULL)
                        full_answers++;
                end
            end
            if (req_valid && !req_stall)
                update_table(op_t'(operation), time_value, packet_length, data_byte);
            if (psel && penable && pready && paddr == REG_PREPARE_TIME)
            begin
                if (pwrite)
                    lead_time = pwdata;
                else
                    compare_field("prepare_time", lead_time, prdata);
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    import tpst_pkg::*;
    import tpst_tb_pkg::*;

    localparam int ITEM_TARGET = 360;
    localparam int PHASES      = 4;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid     = 1'b0;
    logic        req_stall;
    logic [1:0]  operation     = '0;
    logic [31:0] time_value    = '0;
    logic [6:0]  packet_length = '0;
    logic [7:0]  data_byte     = '0;
    logic        res_valid;
    logic        res_stall     = 1'b0;
    logic [1:0]  status;
    logic [31:0] found_time;
    logic [6:0]  result_length;
    logic [7:0]  result_byte;
    logic        byte_valid;
    logic        last;

    int fail_count;
    int outstanding;
    int results_checked;
    int packets_found;
    int full_answers;
    int sent_count     = 0;
    int settings_used  = 0;
    int burst_left     = 0;

    timed_packet_slot_table dut (.*);

    tpst_checker checker_i (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            n = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 60) : $urandom_range(1, 4);
            res_stall <= 1'b0;
            repeat (n) @(posedge clk);
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 20);
            res_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
    end

    function automatic int sender_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(op_t op, logic [31:0] t, logic [6:0] len, logic [7:0] d);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        operation     <= op;
        time_value    <= t;
        packet_length <= len;
        data_byte     <= d;
        do @(posedge clk); while (req_stall);
        sent_count++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(logic write, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= REG_PREPARE_TIME;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_lead_time(logic [31:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        settings_used++;
    endtask

    task automatic random_phase(int quota);
        int          done;
        int          r;
        int          cap;
        int          n;
        logic [31:0] t;
        logic [6:0]  len;
        done = 0;
        while (done < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                r = $urandom_range(0, 99);
                t = (r < 5) ? '0 : (r < 15) ? $urandom : $urandom_range(1, 300);
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = '0;
                else if (r < 70)
                    len = 7'($urandom_range(1, 6));
                else if (r < 90)
                    len = 7'($urandom_range(7, 24));
                else if (r < 97)
                    len = 7'(MAX_BYTES);
                else
                    len = 7'($urandom_range(MAX_BYTES + 1, 127));
                cap = (int'(len) > MAX_BYTES) ? MAX_BYTES : int'(len);
                n   = (int'(len) > MAX_BYTES) ? cap + $urandom_range(1, 3) : cap;
                if (cap > 0 && $urandom_range(0, 99) < 12)
                    n = $urandom_range(0, cap - 1);
                send_request(OP_ADD_START, t, len, 8'($urandom));
                for (int k = 0; k < n; k++)
                    send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'($urandom));
                done += 1 + ((n > cap) ? cap : n);
            end
            else if (r < 80)
            begin
                t = ($urandom_range(0, 99) < 12) ? $urandom : $urandom_range(0, 320);
                send_request(OP_FIND, t, 7'($urandom), 8'($urandom));
                done++;
            end
            else if (r < 88)
            begin
                r = $urandom_range(0, 99);
                t = (r < 20) ? '0 : (r < 25) ? $urandom : $urandom_range(0, 120);
                send_request(OP_CLEAR, t, 7'($urandom), 8'($urandom));
                done++;
            end
            else if (r < 95)
                send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'($urandom));
            else
                drain();
        end
    endtask

    initial
    begin
        logic [31:0] lead_values [PHASES];
        lead_values[0] = 32'd40;
        lead_values[1] = 32'hFFFF_FFFF;
        lead_values[2] = $urandom;
        lead_values[3] = 32'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_lead_time(32'd0);

        send_request(OP_FIND, 32'd0, 7'($urandom), 8'($urandom));
        send_request(OP_ADD_START, 32'd100, 7'd3, 8'($urandom));
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h00);
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'hFF);
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'hA5);
        send_request(OP_ADD_START, 32'hFFFF_FFFF, 7'd0, 8'($urandom));
        send_request(OP_FIND, 32'd100, 7'($urandom), 8'($urandom));
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h5A);
        send_request(OP_ADD_START, 32'd0, 7'd2, 8'($urandom));
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h11);
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h22);
        send_request(OP_ADD_START, 32'd50, 7'd4, 8'($urandom));
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h33);
        send_request(OP_ADD_START, 32'd60, 7'd127, 8'($urandom));
        send_request(OP_ADD_BYTE, $urandom, 7'($urandom), 8'h44);
        send_request(OP_CLEAR, 32'd55, 7'($urandom), 8'($urandom));
        send_request(OP_FIND, 32'hFFFF_FFFF, 7'($urandom), 8'($urandom));
        for (int i = 0; i <= SLOTS; i++)
            send_request(OP_ADD_START, 32'(10 + i), 7'd0, 8'($urandom));
        send_request(OP_FIND, 32'd5, 7'($urandom), 8'($urandom));
        send_request(OP_CLEAR, 32'hFFFF_FFFF, 7'($urandom), 8'($urandom));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_lead_time(lead_values[p]);
            random_phase(ITEM_TARGET / PHASES);
            drain();
        end
        repeat (16) @(posedge clk);

        $display("Drove %0d requests under %0d prepare_time settings, %0d results checked.",
                 sent_count, settings_used, results_checked);
        $display("Find returned %0d packets; %0d adds met a full table.", packets_found,
                 full_answers);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
